// ===== hw/rtl/u8vcs_pkg.sv =====
// shared types and constants for the utf-8 validate / count / substring block
// no dependencies
package u8vcs_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned CFG_WIDTH   = 32;
  localparam int unsigned BYTE_WIDTH  = 8;
  localparam int unsigned CP_WIDTH    = 32;
  localparam int unsigned LEN_WIDTH   = 3;
  localparam int unsigned TOTAL_WIDTH = 32;
  // cp_bytes + cp_length + code_point_total + invalid_seen + substring_complete
  localparam int unsigned OUT_FIELDS_WIDTH = CP_WIDTH + LEN_WIDTH + TOTAL_WIDTH + 2;
  localparam int unsigned OUT_TDATA_WIDTH  = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_SKIP_COUNT = 1'b0,
    CFG_TAKE_COUNT = 1'b1
  } cfg_index_t;

  // result kinds
  typedef enum logic [0:0] {
    KIND_CODE_POINT = 1'b0,
    KIND_STATUS     = 1'b1
  } result_kind_t;

  // allowed range of the next continuation byte
  typedef enum logic [2:0] {
    RANGE_80_BF = 3'd0,
    RANGE_A0_BF = 3'd1,
    RANGE_80_9F = 3'd2,
    RANGE_90_BF = 3'd3,
    RANGE_80_8F = 3'd4
  } byte_range_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

// ===== hw/rtl/utf8_validate_count_substring.sv =====
// utf-8 validator with code point counter and substring extraction
// depends on u8vcs_pkg
//
// Takes one string byte per item and checks it against the well-formed
// utf-8 sequence table; a zero byte ends the string and yields one status
// item (total count, error, substring complete), after which the block
// clears itself while keeping skip_count and take_count. Code points after
// the first skip_count, up to take_count of them, come out as one item each.
// Throughput is one byte per cycle while no result waits on a stalled output.
// The byte sits in the input register while the sequence decode and the
// saturating counters work on it, and its result then goes to the result register.
// The user must write configuration only while no item is in flight; the block does not enforce it.
module utf8_validate_count_substring (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [u8vcs_pkg::CFG_WIDTH-1:0]      cfg_wdata,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [u8vcs_pkg::BYTE_WIDTH-1:0]     in_tdata,   // data_byte
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // cp_bytes[31:0], cp_length[34:32], code_point_total[66:35],
  // invalid_seen[67], substring_complete[68], zero fill above
  output logic [u8vcs_pkg::OUT_TDATA_WIDTH-1:0] out_tdata,
  output logic                                 out_tuser   // result_kind
);

  localparam int unsigned CW = u8vcs_pkg::COUNT_WIDTH;
  localparam int unsigned WW = (CW > u8vcs_pkg::CFG_WIDTH) ? CW + 1 : u8vcs_pkg::CFG_WIDTH + 1;
  localparam logic [CW-1:0] COUNT_MAX = '1;
  localparam int unsigned PAD_WIDTH =
    u8vcs_pkg::OUT_TDATA_WIDTH - u8vcs_pkg::OUT_FIELDS_WIDTH;

  // configuration
  logic [u8vcs_pkg::CFG_WIDTH-1:0] skip_count_r;
  logic [u8vcs_pkg::CFG_WIDTH-1:0] take_count_r;

  // input register
  logic                              s1_valid_r;
  logic [u8vcs_pkg::BYTE_WIDTH-1:0]  s1_byte_r;

  // decoder state
  logic [1:0]                        need_r, need_nxt;
  u8vcs_pkg::byte_range_t            range_r, range_nxt;
  logic [u8vcs_pkg::CP_WIDTH-1:0]    partial_r, partial_nxt;
  logic [u8vcs_pkg::LEN_WIDTH-1:0]   plen_r, plen_nxt;
  u8vcs_pkg::count_t                 seen_r, seen_nxt;
  u8vcs_pkg::count_t                 taken_r, taken_nxt;
  logic                              err_r, err_nxt;

  // result register
  logic                              out_valid_r;
  u8vcs_pkg::result_kind_t           out_kind_r;
  logic [u8vcs_pkg::CP_WIDTH-1:0]    out_cp_r;
  logic [u8vcs_pkg::LEN_WIDTH-1:0]   out_len_r;
  logic [u8vcs_pkg::TOTAL_WIDTH-1:0] out_total_r;
  logic                              out_inv_r;
  logic                              out_sub_r;

  // result of this byte
  logic                              res_valid;
  u8vcs_pkg::result_kind_t           res_kind;
  logic [u8vcs_pkg::CP_WIDTH-1:0]    res_cp;
  logic [u8vcs_pkg::LEN_WIDTH-1:0]   res_len;
  logic [u8vcs_pkg::TOTAL_WIDTH-1:0] res_total;
  logic                              res_inv;
  logic                              res_sub;

  logic                              advance;

  // working values
  logic [7:0]                        b;
  logic                              cont_ok;
  logic                              lead_ok;
  logic [1:0]                        lead_need;
  u8vcs_pkg::byte_range_t            lead_range;
  logic                              finish;
  logic [u8vcs_pkg::CP_WIDTH-1:0]    cp_built;
  logic [u8vcs_pkg::LEN_WIDTH-1:0]   len_built;
  u8vcs_pkg::count_t                 seen_inc;
  logic                              bad_end;

  assign b = s1_byte_r;

  always_comb begin
    case (range_r)
      u8vcs_pkg::RANGE_A0_BF: cont_ok = (b >= 8'hA0) && (b <= 8'hBF);
      u8vcs_pkg::RANGE_80_9F: cont_ok = (b >= 8'h80) && (b <= 8'h9F);
      u8vcs_pkg::RANGE_90_BF: cont_ok = (b >= 8'h90) && (b <= 8'hBF);
      u8vcs_pkg::RANGE_80_8F: cont_ok = (b >= 8'h80) && (b <= 8'h8F);
      default:                cont_ok = (b >= 8'h80) && (b <= 8'hBF);
    endcase
  end

  always_comb begin
    lead_ok    = 1'b1;
    lead_need  = 2'd0;
    lead_range = u8vcs_pkg::RANGE_80_BF;
    case (b) inside
      [8'h00:8'h7F]: lead_need = 2'd0;
      [8'hC2:8'hDF]: lead_need = 2'd1;
      8'hE0: begin
        lead_need  = 2'd2;
        lead_range = u8vcs_pkg::RANGE_A0_BF;
      end
      8'hED: begin
        lead_need  = 2'd2;
        lead_range = u8vcs_pkg::RANGE_80_9F;
      end
      [8'hE1:8'hEC], [8'hEE:8'hEF]: lead_need = 2'd2;
      8'hF0: begin
        lead_need  = 2'd3;
        lead_range = u8vcs_pkg::RANGE_90_BF;
      end
      8'hF4: begin
        lead_need  = 2'd3;
        lead_range = u8vcs_pkg::RANGE_80_8F;
      end
      [8'hF1:8'hF3]: lead_need = 2'd3;
      default: lead_ok = 1'b0;
    endcase
  end

  // continuation byte lands in the lane after the gathered ones
  assign cp_built  = partial_r |
    (u8vcs_pkg::CP_WIDTH'(b) << {plen_r[1:0], 3'b000});
  assign len_built = plen_r + u8vcs_pkg::LEN_WIDTH'(1);
  assign seen_inc  = (seen_r == COUNT_MAX) ? seen_r : seen_r + CW'(1);
  assign bad_end   = err_r || (need_r != 2'd0);

  always_comb begin
    need_nxt    = need_r;
    range_nxt   = range_r;
    partial_nxt = partial_r;
    plen_nxt    = plen_r;
    seen_nxt    = seen_r;
    taken_nxt   = taken_r;
    err_nxt     = err_r;
    finish      = 1'b0;
    res_valid   = 1'b0;
    res_kind    = u8vcs_pkg::KIND_CODE_POINT;
    res_cp      = '0;
    res_len     = '0;
    res_total   = '0;
    res_inv     = 1'b0;
    res_sub     = 1'b0;

    if (b == 8'h00) begin
      // terminator: status item, then back to the cleared state
      res_valid = 1'b1;
      res_kind  = u8vcs_pkg::KIND_STATUS;
      res_inv   = bad_end;
      if (!bad_end) begin
        res_total = (WW'(seen_r) > WW'(32'hFFFF_FFFF)) ? '1 :
                    u8vcs_pkg::TOTAL_WIDTH'(seen_r);
      end
      res_sub = (take_count_r != '0) && (WW'(taken_r) == WW'(take_count_r));
      need_nxt    = 2'd0;
      range_nxt   = u8vcs_pkg::RANGE_80_BF;
      partial_nxt = '0;
      plen_nxt    = '0;
      seen_nxt    = '0;
      taken_nxt   = '0;
      err_nxt     = 1'b0;
    end else if (!err_r) begin
      if (need_r == 2'd0) begin
        if (!lead_ok) begin
          err_nxt = 1'b1;
        end else begin
          partial_nxt = u8vcs_pkg::CP_WIDTH'(b);
          plen_nxt    = u8vcs_pkg::LEN_WIDTH'(1);
          need_nxt    = lead_need;
          range_nxt   = lead_range;
          finish      = (lead_need == 2'd0);
        end
      end else if (!cont_ok) begin
        err_nxt     = 1'b1;
        need_nxt    = 2'd0;
        range_nxt   = u8vcs_pkg::RANGE_80_BF;
        partial_nxt = '0;
        plen_nxt    = '0;
      end else begin
        partial_nxt = cp_built;
        plen_nxt    = len_built;
        need_nxt    = need_r - 2'd1;
        range_nxt   = u8vcs_pkg::RANGE_80_BF;
        finish      = (need_r == 2'd1);
      end

      if (finish) begin
        seen_nxt = seen_inc;
        if ((WW'(seen_inc) > WW'(skip_count_r)) && (WW'(taken_r) < WW'(take_count_r))) begin
          res_valid = 1'b1;
          res_cp    = partial_nxt;
          res_len   = plen_nxt;
          taken_nxt = (taken_r == COUNT_MAX) ? taken_r : taken_r + CW'(1);
        end
        need_nxt    = 2'd0;
        range_nxt   = u8vcs_pkg::RANGE_80_BF;
        partial_nxt = '0;
        plen_nxt    = '0;
      end
    end
  end

  // a byte with no result never waits on the output side
  assign advance   = s1_valid_r && (!res_valid || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= '0;
      take_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        u8vcs_pkg::CFG_SKIP_COUNT: skip_count_r <= cfg_wdata;
        u8vcs_pkg::CFG_TAKE_COUNT: take_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r    <= 2'd0;
      range_r   <= u8vcs_pkg::RANGE_80_BF;
      partial_r <= '0;
      plen_r    <= '0;
      seen_r    <= '0;
      taken_r   <= '0;
      err_r     <= 1'b0;
    end else if (advance) begin
      need_r    <= need_nxt;
      range_r   <= range_nxt;
      partial_r <= partial_nxt;
      plen_r    <= plen_nxt;
      seen_r    <= seen_nxt;
      taken_r   <= taken_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind_r  <= res_kind;
      out_cp_r    <= res_cp;
      out_len_r   <= res_len;
      out_total_r <= res_total;
      out_inv_r   <= res_inv;
      out_sub_r   <= res_sub;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{PAD_WIDTH{1'b0}}, out_sub_r, out_inv_r, out_total_r,
                       out_len_r, out_cp_r};

endmodule
